FILE: sv/rate_clocked_lfsr_noise_unit_macros.svh
// ----------------------------------------------------------------------------
// rate_clocked_lfsr_noise_unit_macros.svh
// Assertion macros for the rate clocked LFSR noise unit. Assertions compile
// away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RATE_CLOCKED_LFSR_NOISE_UNIT_MACROS_SVH
`define RATE_CLOCKED_LFSR_NOISE_UNIT_MACROS_SVH

`ifndef SYNTH
// checked only outside reset
`define RCLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define RCLN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RCLN_ASSERT(lbl, prop, msg)
`define RCLN_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: sv/rclfsr_pkg.sv
// ----------------------------------------------------------------------------
// rclfsr_pkg
// Widths, state encoding, control struct and LFSR step function shared by
// the noise unit and its submodules.
// ----------------------------------------------------------------------------
package rclfsr_pkg;

  // field widths
  localparam int FREQ_W  = 24;
  localparam int SYNC_W  = 16;
  localparam int GAIN_W  = 24;
  localparam int NOISE_W = 16;
  localparam int ONE_W   = 17;

  // datapath widths
  localparam int MAG_W      = FREQ_W - 1;          // non-negative frequency
  localparam int PROD_W     = GAIN_W + MAG_W;      // full product
  localparam int INC_SHIFT  = 8;                   // Q15.32 -> Q15.24
  localparam int INC_W      = PROD_W - INC_SHIFT;
  localparam int FRAC_W     = 24;                  // phase fraction
  localparam int TOTAL_W    = INC_W + 1;
  localparam int STEP_W     = TOTAL_W - FRAC_W;    // whole steps
  localparam int MUL_CNT_W  = $clog2(MAG_W);

  // LFSR
  localparam int LFSR_W     = 23;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 23'd1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 23'h420000; // bits 22 and 17

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd3804357;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_DONE
  } state_t;

  // control from the sequencer to the LFSR stepper
  typedef struct packed {
    logic reload;   // restart at the seed
    logic start;    // load the step count
  } lfsr_ctrl_t;

  // one Galois step, shift right with feedback from bit 0
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] r);
    lfsr_next = (r >> 1) ^ (r[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

FILE: sv/rclfsr_mul.sv
// ----------------------------------------------------------------------------
// rclfsr_mul
// Shift-add multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module rclfsr_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [rclfsr_pkg::GAIN_W-1:0]    mcand,
  input  logic [rclfsr_pkg::MAG_W-1:0]     mplier,
  output logic [rclfsr_pkg::PROD_W-1:0]    prod,
  output logic                             done
);

  logic [rclfsr_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [rclfsr_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                             run_r, run_nxt;
  logic                             done_r, done_nxt;
  logic [rclfsr_pkg::GAIN_W-1:0]    addend;
  logic [rclfsr_pkg::GAIN_W:0]      sum;
  logic                             last;

  // partial product: add into the upper half, shift the word right
  always_comb begin
    addend   = prod_r[0] ? mcand : '0;
    sum      = {1'b0, prod_r[rclfsr_pkg::PROD_W-1:rclfsr_pkg::MAG_W]} + {1'b0, addend};
    last     = (cnt_r == rclfsr_pkg::MUL_CNT_W'(rclfsr_pkg::MAG_W - 1));
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      prod_nxt = {rclfsr_pkg::GAIN_W'(0), mplier};
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      prod_nxt = {sum, prod_r[rclfsr_pkg::MAG_W-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (last) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

FILE: sv/rclfsr_lfsr.sv
// ----------------------------------------------------------------------------
// rclfsr_lfsr
// 23-bit Galois LFSR with a down counter: steps once per cycle until the
// loaded count runs out.
// ----------------------------------------------------------------------------
module rclfsr_lfsr #(
  parameter int CNT_W = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rclfsr_pkg::lfsr_ctrl_t          ctrl,
  input  logic [CNT_W-1:0]                count,
  output logic [rclfsr_pkg::LFSR_W-1:0]   lfsr_q,
  output logic                            busy
);

  logic [rclfsr_pkg::LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  // step while the count is nonzero
  always_comb begin
    busy     = (cnt_r != '0);
    lfsr_nxt = lfsr_r;
    cnt_nxt  = cnt_r;
    if (ctrl.reload) begin
      lfsr_nxt = rclfsr_pkg::LFSR_SEED;
    end else if (busy) begin
      lfsr_nxt = rclfsr_pkg::lfsr_next(lfsr_r);
    end
    if (ctrl.start) begin
      cnt_nxt = count;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= rclfsr_pkg::LFSR_SEED;
      cnt_r  <= '0;
    end else begin
      lfsr_r <= lfsr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign lfsr_q = lfsr_r;

endmodule

FILE: sv/rate_clocked_lfsr_noise_unit.sv
// ----------------------------------------------------------------------------
// rate_clocked_lfsr_noise_unit
// Rate clocked noise source: frequency times gain feeds a phase
// accumulator, and each whole unit of phase steps a 23-bit Galois LFSR.
//
//   channel  direction  handshake           data
//   in       input      in_valid/in_ready   in_frequency, in_sync
//   out      output     out_valid/out_ready noise views, steps_clipped
//   cfg      input      cfg_we              cfg_wdata (rate gain)
//
// From accept to result valid a word passes the bit-serial multiply, the
// phase add, n LFSR steps, n being the clipped step count (0..MAX_STEPS),
// the check that the stepper has finished and the load of the output
// register. The LFSR stepper takes one step per cycle; the next word can
// be taken in the cycle after the output load.
// A result waits in the output register while the next word is at work.
// Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
`include "rate_clocked_lfsr_noise_unit_macros.svh"

module rate_clocked_lfsr_noise_unit #(
  parameter int MAX_STEPS = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rclfsr_pkg::FREQ_W-1:0] in_frequency,
  input  logic signed [rclfsr_pkg::SYNC_W-1:0] in_sync,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rclfsr_pkg::NOISE_W-1:0] out_noise_full,
  output logic signed [rclfsr_pkg::NOISE_W-1:0] out_noise_four_bit,
  output logic signed [rclfsr_pkg::ONE_W-1:0]   out_noise_one_bit,
  output logic                              out_steps_clipped,
  // configuration
  input  logic                              cfg_we,
  input  logic [rclfsr_pkg::GAIN_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  rclfsr_pkg::state_t              state_r, state_nxt;
  logic [rclfsr_pkg::GAIN_W-1:0]   gain_r;
  logic [rclfsr_pkg::FRAC_W-1:0]   phase_r, phase_nxt;
  logic                            sync_pos_r, sync_pos_nxt;
  logic                            clip_r, clip_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [rclfsr_pkg::NOISE_W-1:0]  full_r;
  logic [rclfsr_pkg::NOISE_W-1:0]  four_r;
  logic [rclfsr_pkg::ONE_W-1:0]    one_r;
  logic                            oclip_r;
  logic                            load_out;

  logic                            accept;
  logic                            sync_pos;
  logic [rclfsr_pkg::MAG_W-1:0]    freq_mag;
  logic [rclfsr_pkg::PROD_W-1:0]   mul_prod;
  logic                            mul_done;
  logic [rclfsr_pkg::TOTAL_W-1:0]  total;
  logic [rclfsr_pkg::STEP_W-1:0]   steps;
  logic                            over;
  logic [CNT_W-1:0]                step_cnt;
  rclfsr_pkg::lfsr_ctrl_t          lfsr_ctrl;
  logic [rclfsr_pkg::LFSR_W-1:0]   lfsr_q;
  logic                            lfsr_busy;

  // input decode
  assign accept   = in_valid && in_ready;
  assign sync_pos = !in_sync[rclfsr_pkg::SYNC_W-1] && (in_sync != '0);
  assign freq_mag = in_frequency[rclfsr_pkg::FREQ_W-1] ? '0
                                                        : in_frequency[rclfsr_pkg::MAG_W-1:0];

  rclfsr_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .mcand  (gain_r),
    .mplier (freq_mag),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  // phase add and step clamp
  always_comb begin
    total = {{(rclfsr_pkg::TOTAL_W - rclfsr_pkg::FRAC_W){1'b0}}, phase_r}
          + {1'b0, mul_prod[rclfsr_pkg::PROD_W-1:rclfsr_pkg::INC_SHIFT]};
    steps = total[rclfsr_pkg::TOTAL_W-1:rclfsr_pkg::FRAC_W];
    over  = (steps > rclfsr_pkg::STEP_W'(MAX_STEPS));
    step_cnt = over ? CNT_W'(MAX_STEPS) : steps[CNT_W-1:0];
  end

  rclfsr_lfsr #(
    .CNT_W (CNT_W)
  ) u_lfsr (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lfsr_ctrl),
    .count  (step_cnt),
    .lfsr_q (lfsr_q),
    .busy   (lfsr_busy)
  );

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    sync_pos_nxt     = sync_pos_r;
    clip_nxt         = clip_r;
    lfsr_ctrl.reload = 1'b0;
    lfsr_ctrl.start  = 1'b0;
    load_out         = 1'b0;
    in_ready         = (state_r == rclfsr_pkg::ST_IDLE);
    unique case (state_r)
      rclfsr_pkg::ST_IDLE: begin
        if (in_valid) begin
          sync_pos_nxt = sync_pos;
          if (sync_pos && !sync_pos_r) begin
            phase_nxt        = '0;
            lfsr_ctrl.reload = 1'b1;
          end
          state_nxt = rclfsr_pkg::ST_MUL;
        end
      end
      rclfsr_pkg::ST_MUL: begin
        if (mul_done) begin
          phase_nxt       = total[rclfsr_pkg::FRAC_W-1:0];
          clip_nxt        = over;
          lfsr_ctrl.start = 1'b1;
          state_nxt       = rclfsr_pkg::ST_STEP;
        end
      end
      rclfsr_pkg::ST_STEP: begin
        if (!lfsr_busy) begin
          state_nxt = rclfsr_pkg::ST_DONE;
        end
      end
      rclfsr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = rclfsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rclfsr_pkg::ST_IDLE;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rclfsr_pkg::ST_IDLE;
      gain_r      <= rclfsr_pkg::GAIN_RESET;
      phase_r     <= '0;
      sync_pos_r  <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      sync_pos_r  <= sync_pos_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
    end
  end

  // output register: signed two's complement views of the LFSR bits
  always_ff @(posedge clk) begin
    if (load_out) begin
      full_r  <= {~lfsr_q[15], lfsr_q[14:0]};
      four_r  <= {~lfsr_q[15], lfsr_q[14:12], 12'd0};
      one_r   <= {~lfsr_q[16], 1'b1, 15'd0};
      oclip_r <= clip_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_noise_full     = full_r;
  assign out_noise_four_bit = four_r;
  assign out_noise_one_bit  = one_r;
  assign out_steps_clipped  = oclip_r;

  // checks
  `RCLN_ASSERT(a_lfsr_nonzero, lfsr_q != '0, "LFSR reached the all-zero state")
  `RCLN_ASSERT(a_idle_quiet, in_ready |-> !lfsr_busy, "LFSR stepping while idle")
  `RCLN_ASSERT(a_mul_in_mul, mul_done |-> state_r == rclfsr_pkg::ST_MUL, "product outside MUL")
  `RCLN_ASSERT_RST(a_reset_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
